>>> sv/pct_pkg.sv
package pct_pkg;

  localparam int COUNTER_WIDTH  = 24;
  localparam int PRESCALE_WIDTH = 8;
  localparam int DATA_WIDTH     = 32;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  localparam logic [1:0] REG_CTRL    = 2'd0;
  localparam logic [1:0] REG_COMPARE = 2'd1;
  localparam logic [1:0] REG_STATUS  = 2'd2;
  localparam logic [1:0] REG_COUNT   = 2'd3;

  localparam logic [1:0] MODE_ONESHOT    = 2'd0;
  localparam logic [1:0] MODE_PERIODIC   = 2'd1;
  localparam logic [1:0] MODE_TOGGLE     = 2'd2;
  localparam logic [1:0] MODE_CONTINUOUS = 2'd3;

  localparam int CTRL_EN_BIT   = 30;
  localparam int CTRL_IE_BIT   = 29;
  localparam int CTRL_MODE_LSB = 27;
  localparam int CTRL_ACT_BIT  = 25;
  localparam int STAT_FLAG_BIT = 0;

  typedef struct packed {
    logic [1:0]            func;
    logic [1:0]            reg_index;
    logic [DATA_WIDTH-1:0] write_data;
  } pct_req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_data;
    logic                  interrupt;
    logic                  toggle_level;
  } pct_rsp_t;

endpackage

>>> sv/pct_if.sv
interface pct_req_if;
  import pct_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [1:0]            func;
  logic [1:0]            reg_index;
  logic [DATA_WIDTH-1:0] write_data;

  modport source (output valid, output func, output reg_index, output write_data,
                  input ready);
  modport sink (input valid, input func, input reg_index, input write_data,
                output ready);
endinterface

interface pct_rsp_if;
  import pct_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] read_data;
  logic                  interrupt;
  logic                  toggle_level;

  modport source (output valid, output read_data, output interrupt, output toggle_level,
                  input ready);
  modport sink (input valid, input read_data, input interrupt, input toggle_level,
                output ready);
endinterface

>>> sv/pct_core.sv
module pct_core
  import pct_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  pct_req_t req,
  output pct_rsp_t rsp
);

  logic                      en_r, en_nxt;
  logic                      ie_r, ie_nxt;
  logic [1:0]                mode_r, mode_nxt;
  logic [PRESCALE_WIDTH-1:0] psc_val_r, psc_val_nxt;
  logic [PRESCALE_WIDTH-1:0] psc_cnt_r, psc_cnt_nxt;
  logic [COUNTER_WIDTH-1:0]  cmp_r, cmp_nxt;
  logic [COUNTER_WIDTH-1:0]  cnt_r, cnt_nxt;
  logic                      flag_r, flag_nxt;
  logic                      tgl_r, tgl_nxt;
  logic [COUNTER_WIDTH-1:0]  cnt_inc;
  logic [DATA_WIDTH-1:0]     rd;

  assign cnt_inc = cnt_r + COUNTER_WIDTH'(1);

  always_comb begin
    en_nxt      = en_r;
    ie_nxt      = ie_r;
    mode_nxt    = mode_r;
    psc_val_nxt = psc_val_r;
    psc_cnt_nxt = psc_cnt_r;
    cmp_nxt     = cmp_r;
    cnt_nxt     = cnt_r;
    flag_nxt    = flag_r;
    tgl_nxt     = tgl_r;
    case (req.func)
      FUNC_TICK: begin
        if (en_r) begin
          if (psc_cnt_r < psc_val_r) begin
            psc_cnt_nxt = psc_cnt_r + PRESCALE_WIDTH'(1);
          end else begin
            psc_cnt_nxt = '0;
            cnt_nxt     = cnt_inc;
            if (cnt_inc == cmp_r) begin
              flag_nxt = 1'b1;
              case (mode_r)
                MODE_ONESHOT: begin
                  en_nxt  = 1'b0;
                  cnt_nxt = '0;
                end
                MODE_PERIODIC: begin
                  cnt_nxt = '0;
                end
                MODE_TOGGLE: begin
                  cnt_nxt = '0;
                  tgl_nxt = ~tgl_r;
                end
                default: begin
                  cnt_nxt = cnt_inc;
                end
              endcase
            end
          end
        end
      end
      FUNC_WRITE: begin
        case (req.reg_index)
          REG_CTRL: begin
            en_nxt      = req.write_data[CTRL_EN_BIT];
            ie_nxt      = req.write_data[CTRL_IE_BIT];
            mode_nxt    = req.write_data[CTRL_MODE_LSB +: 2];
            psc_val_nxt = req.write_data[PRESCALE_WIDTH-1:0];
          end
          REG_COMPARE: cmp_nxt = req.write_data[COUNTER_WIDTH-1:0];
          REG_STATUS: begin
            if (req.write_data[STAT_FLAG_BIT]) begin
              flag_nxt = 1'b0;
            end
          end
          default: cnt_nxt = req.write_data[COUNTER_WIDTH-1:0];
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rd = '0;
    if (req.func == FUNC_READ) begin
      case (req.reg_index)
        REG_CTRL: begin
          rd[CTRL_EN_BIT]                = en_r;
          rd[CTRL_ACT_BIT]               = en_r;
          rd[CTRL_IE_BIT]                = ie_r;
          rd[CTRL_MODE_LSB +: 2]         = mode_r;
          rd[PRESCALE_WIDTH-1:0]         = psc_val_r;
        end
        REG_COMPARE: rd = DATA_WIDTH'(cmp_r);
        REG_STATUS:  rd[STAT_FLAG_BIT] = flag_r;
        default:     rd = DATA_WIDTH'(cnt_r);
      endcase
    end
  end

  assign rsp.read_data    = rd;
  assign rsp.interrupt    = flag_nxt & ie_nxt;
  assign rsp.toggle_level = tgl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r      <= 1'b0;
      ie_r      <= 1'b0;
      mode_r    <= MODE_ONESHOT;
      psc_val_r <= '0;
      psc_cnt_r <= '0;
      cmp_r     <= '0;
      cnt_r     <= '0;
      flag_r    <= 1'b0;
      tgl_r     <= 1'b0;
    end else if (step) begin
      en_r      <= en_nxt;
      ie_r      <= ie_nxt;
      mode_r    <= mode_nxt;
      psc_val_r <= psc_val_nxt;
      psc_cnt_r <= psc_cnt_nxt;
      cmp_r     <= cmp_nxt;
      cnt_r     <= cnt_nxt;
      flag_r    <= flag_nxt;
      tgl_r     <= tgl_nxt;
    end
  end

endmodule

>>> sv/prescaled_compare_timer.sv
// Prescaled compare-match timer. Each request is a tick, a register read, a
// register write or a no-op (function code 3); every request yields one
// response carrying read data (zero for all but reads), the interrupt line and
// the toggle level after the request. One request is taken per cycle while the
// receiver takes each response. An accepted request loads the request register;
// when it advances, the timer state updates and the response register loads,
// and the response is offered from there. While a response waits for the
// receiver, the request register holds one more request and the input stalls.
module prescaled_compare_timer
  import pct_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pct_req_if.sink   in_req,
  pct_rsp_if.source out_rsp
);

  logic     req_valid_r;
  pct_req_t req_r;
  logic     rsp_valid_r;
  pct_rsp_t rsp_r;
  pct_rsp_t rsp_nxt;
  logic     advance;

  assign advance      = req_valid_r & (~rsp_valid_r | out_rsp.ready);
  assign in_req.ready = ~req_valid_r | advance;

  pct_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .req   (req_r),
    .rsp   (rsp_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      req_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      req_r.func       <= in_req.func;
      req_r.reg_index  <= in_req.reg_index;
      req_r.write_data <= in_req.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_valid_r <= 1'b0;
    end else if (advance) begin
      rsp_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      rsp_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_rsp.valid        = rsp_valid_r;
  assign out_rsp.read_data    = rsp_r.read_data;
  assign out_rsp.interrupt    = rsp_r.interrupt;
  assign out_rsp.toggle_level = rsp_r.toggle_level;

endmodule
